// ----- hw/rtl/nps_pkg.sv -----
// ----------------------------------------------------------------------------
// nps_pkg: shared definitions for the nearest point sorter
// Default sizes, register indexes and the command word that drives the cells.
// ----------------------------------------------------------------------------
package nps_pkg;

   localparam int MAX_POINTS_DEF = 8;
   localparam int COORD_BITS_DEF = 7;
   localparam int DIST_BITS      = 16;
   localparam int CSR_INDEX_BITS = 2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_REF_X = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_REF_Y = 2'd1;

   // Command broadcast to every cell of the sorting chain.
   typedef struct packed {
      logic insert;  // place the new item in order, shifting larger keys right
      logic pop;     // shift the whole chain one place toward cell zero
   } cell_cmd_type;

endpackage

// ----- hw/rtl/nps_dist.sv -----
// ----------------------------------------------------------------------------
// nps_dist: squared distance pipeline
// Three register stages: coordinate differences, squares, and their sum.
// ----------------------------------------------------------------------------
module nps_dist #(
   parameter int COORD_BITS = 7
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  logic signed [COORD_BITS-1:0] in_x,
   input  logic signed [COORD_BITS-1:0] in_y,
   input  logic                         in_last,
   input  logic signed [COORD_BITS-1:0] ref_x,
   input  logic signed [COORD_BITS-1:0] ref_y,
   output logic                         key_valid,
   output logic signed [COORD_BITS-1:0] key_x,
   output logic signed [COORD_BITS-1:0] key_y,
   output logic                         key_last,
   output logic [2*COORD_BITS+1:0]      key
);

   localparam int SQ_BITS  = 2*COORD_BITS + 1;
   localparam int KEY_BITS = 2*COORD_BITS + 2;

   logic                         s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic                         s1_last_ff, s2_last_ff, s3_last_ff;
   logic signed [COORD_BITS-1:0] s1_x_ff, s1_y_ff, s2_x_ff, s2_y_ff, s3_x_ff, s3_y_ff;
   logic signed [COORD_BITS:0]   dx_in, dy_in, dx_ff, dy_ff;
   logic signed [2*COORD_BITS+1:0] prod_x, prod_y;
   logic [SQ_BITS-1:0]           sqx_in, sqy_in, sqx_ff, sqy_ff;
   logic [KEY_BITS-1:0]          key_in, key_ff;

   always_comb begin
      dx_in  = $signed({ref_x[COORD_BITS-1], ref_x}) - $signed({in_x[COORD_BITS-1], in_x});
      dy_in  = $signed({ref_y[COORD_BITS-1], ref_y}) - $signed({in_y[COORD_BITS-1], in_y});
      prod_x = dx_ff * dx_ff;
      prod_y = dy_ff * dy_ff;
      // Squares are never negative, so the sign bit can go.
      sqx_in = prod_x[SQ_BITS-1:0];
      sqy_in = prod_y[SQ_BITS-1:0];
      key_in = {1'b0, sqx_ff} + {1'b0, sqy_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      dx_ff      <= dx_in;
      dy_ff      <= dy_in;
      s1_x_ff    <= in_x;
      s1_y_ff    <= in_y;
      s1_last_ff <= in_last;
      sqx_ff     <= sqx_in;
      sqy_ff     <= sqy_in;
      s2_x_ff    <= s1_x_ff;
      s2_y_ff    <= s1_y_ff;
      s2_last_ff <= s1_last_ff;
      key_ff     <= key_in;
      s3_x_ff    <= s2_x_ff;
      s3_y_ff    <= s2_y_ff;
      s3_last_ff <= s2_last_ff;
   end

   assign key_valid = s3_valid_ff;
   assign key_x     = s3_x_ff;
   assign key_y     = s3_y_ff;
   assign key_last  = s3_last_ff;
   assign key       = key_ff;

endmodule

// ----- hw/rtl/nps_cell.sv -----
// ----------------------------------------------------------------------------
// nps_cell: one slot of the sorting chain
// Holds one point and its key; on insert it keeps its entry, takes the new
// item, or takes its left neighbor's entry; on pop it takes the right one's.
// ----------------------------------------------------------------------------
module nps_cell #(
   parameter int COORD_BITS = 7
) (
   input  logic                         clock,
   input  logic                         reset,
   input  nps_pkg::cell_cmd_type        cmd,
   input  logic signed [COORD_BITS-1:0] new_x,
   input  logic signed [COORD_BITS-1:0] new_y,
   input  logic [2*COORD_BITS+1:0]      new_key,
   input  logic                         left_slot,
   input  logic                         left_valid,
   input  logic signed [COORD_BITS-1:0] left_x,
   input  logic signed [COORD_BITS-1:0] left_y,
   input  logic [2*COORD_BITS+1:0]      left_key,
   input  logic                         right_valid,
   input  logic signed [COORD_BITS-1:0] right_x,
   input  logic signed [COORD_BITS-1:0] right_y,
   input  logic [2*COORD_BITS+1:0]      right_key,
   output logic                         slot,
   output logic                         valid,
   output logic signed [COORD_BITS-1:0] x,
   output logic signed [COORD_BITS-1:0] y,
   output logic [2*COORD_BITS+1:0]      key
);

   import nps_pkg::*;

   logic                         valid_in, valid_ff;
   logic signed [COORD_BITS-1:0] x_in, x_ff, y_in, y_ff;
   logic [2*COORD_BITS+1:0]      key_in, key_ff;

   // An equal key stays ahead of the new item, which keeps arrival order.
   assign slot = !valid_ff || (key_ff > new_key);

   always_comb begin
      valid_in = valid_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      key_in   = key_ff;
      priority if (cmd.pop) begin
         valid_in = right_valid;
         x_in     = right_x;
         y_in     = right_y;
         key_in   = right_key;
      end else if (cmd.insert && left_slot) begin
         valid_in = left_valid;
         x_in     = left_x;
         y_in     = left_y;
         key_in   = left_key;
      end else if (cmd.insert && slot) begin
         valid_in = 1'b1;
         x_in     = new_x;
         y_in     = new_y;
         key_in   = new_key;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      y_ff   <= y_in;
      key_ff <= key_in;
   end

   assign valid = valid_ff;
   assign x     = x_ff;
   assign y     = y_ff;
   assign key   = key_ff;

endmodule

// ----- hw/rtl/nearest_point_sort_top.sv -----
// ----------------------------------------------------------------------------
// nearest_point_sort_top: sorts a batch of points by distance to a reference
// Squared-distance pipeline feeding an insertion chain of MAX_POINTS cells.
// ----------------------------------------------------------------------------
// Usage:
//  - The csr channel sets the reference point (index 0 = x, 1 = y); write it
//    only while no batch is in flight. csr_ready is always high.
//  - The req channel takes one point per item, one item per cycle while
//    req_tready is high; tlast marks the final point of a batch. Each point
//    passes the distance pipeline, then is placed in order in the cell chain.
//  - After the last point is accepted, req_tready drops. Once that point has
//    passed the distance pipeline, the chain starts shifting out toward the
//    rsp channel, one item per cycle while the receiver is ready, nearest
//    first; tlast marks the farthest point and tuser flags a batch that lost
//    points because all MAX_POINTS cells were full.
//  - When the receiver stalls, the output register holds its item and the
//    chain waits; req_tready returns once the final item has left the chain.
//  - Reset empties the chain, zeroes the reference point and drops rsp_tvalid.
// ----------------------------------------------------------------------------
module nearest_point_sort_top #(
   parameter int MAX_POINTS = nps_pkg::MAX_POINTS_DEF,
   parameter int COORD_BITS = nps_pkg::COORD_BITS_DEF
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_tvalid,
   output logic                                       req_tready,
   // point_x, point_y
   input  logic [((2*COORD_BITS+7)/8)*8-1:0]          req_tdata,
   input  logic                                       req_tlast,
   output logic                                       rsp_tvalid,
   input  logic                                       rsp_tready,
   // out_x, out_y, dist_sq
   output logic [((2*COORD_BITS+nps_pkg::DIST_BITS+7)/8)*8-1:0] rsp_tdata,
   output logic                                       rsp_tlast,
   // dropped
   output logic                                       rsp_tuser,
   input  logic                                       csr_valid,
   output logic                                       csr_ready,
   input  logic [nps_pkg::CSR_INDEX_BITS-1:0]         csr_index,
   input  logic [COORD_BITS-1:0]                      csr_data
);

   import nps_pkg::*;

   localparam int KEY_BITS = 2*COORD_BITS + 2;
   localparam int SAT_BITS = (KEY_BITS > DIST_BITS) ? KEY_BITS : DIST_BITS;
   localparam int RSP_W    = ((2*COORD_BITS + DIST_BITS + 7)/8)*8;
   localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

   logic signed [COORD_BITS-1:0] ref_x_ff, ref_y_ff;
   logic signed [COORD_BITS-1:0] req_x, req_y;
   logic                         req_take;

   logic                         key_valid, key_last;
   logic signed [COORD_BITS-1:0] key_x, key_y;
   logic [KEY_BITS-1:0]          key;

   logic                         cell_slot  [MAX_POINTS];
   logic                         cell_valid [MAX_POINTS];
   logic signed [COORD_BITS-1:0] cell_x     [MAX_POINTS];
   logic signed [COORD_BITS-1:0] cell_y     [MAX_POINTS];
   logic [KEY_BITS-1:0]          cell_key   [MAX_POINTS];
   cell_cmd_type                 cmd;

   logic hold_in, hold_ff, emit_in, emit_ff, overflow_in, overflow_ff;
   logic full, pop, final_pop;

   logic                         rsp_valid_in, rsp_valid_ff;
   logic signed [COORD_BITS-1:0] rsp_x_ff, rsp_y_ff;
   logic [DIST_BITS-1:0]         rsp_dist_in, rsp_dist_ff;
   logic                         rsp_last_ff, rsp_drop_ff;
   logic [SAT_BITS-1:0]          key0_wide;

   // Configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_x_ff <= '0;
         ref_y_ff <= '0;
      end else if (csr_valid) begin
         if (csr_index == CSR_REF_X) begin
            ref_x_ff <= csr_data;
         end
         if (csr_index == CSR_REF_Y) begin
            ref_y_ff <= csr_data;
         end
      end
   end

   // Input side
   assign req_x      = req_tdata[COORD_BITS-1:0];
   assign req_y      = req_tdata[2*COORD_BITS-1:COORD_BITS];
   assign req_tready = !hold_ff;
   assign req_take   = req_tvalid && req_tready;

   nps_dist #(
      .COORD_BITS (COORD_BITS)
   ) u_dist (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_take),
      .in_x      (req_x),
      .in_y      (req_y),
      .in_last   (req_tlast),
      .ref_x     (ref_x_ff),
      .ref_y     (ref_y_ff),
      .key_valid (key_valid),
      .key_x     (key_x),
      .key_y     (key_y),
      .key_last  (key_last),
      .key       (key)
   );

   // Sorting chain
   assign full       = cell_valid[MAX_POINTS-1];
   assign pop        = emit_ff && (!rsp_valid_ff || rsp_tready);
   assign final_pop  = pop && !cell_valid[1];
   assign cmd.insert = key_valid && !full;
   assign cmd.pop    = pop;

   for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
      logic                         l_slot, l_valid, r_valid;
      logic signed [COORD_BITS-1:0] l_x, l_y, r_x, r_y;
      logic [KEY_BITS-1:0]          l_key, r_key;

      if (i == 0) begin : g_first
         assign l_slot  = 1'b0;
         assign l_valid = 1'b0;
         assign l_x     = '0;
         assign l_y     = '0;
         assign l_key   = '0;
      end else begin : g_inner
         assign l_slot  = cell_slot[i-1];
         assign l_valid = cell_valid[i-1];
         assign l_x     = cell_x[i-1];
         assign l_y     = cell_y[i-1];
         assign l_key   = cell_key[i-1];
      end

      if (i == MAX_POINTS-1) begin : g_end
         assign r_valid = 1'b0;
         assign r_x     = '0;
         assign r_y     = '0;
         assign r_key   = '0;
      end else begin : g_mid
         assign r_valid = cell_valid[i+1];
         assign r_x     = cell_x[i+1];
         assign r_y     = cell_y[i+1];
         assign r_key   = cell_key[i+1];
      end

      nps_cell #(
         .COORD_BITS (COORD_BITS)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .new_x       (key_x),
         .new_y       (key_y),
         .new_key     (key),
         .left_slot   (l_slot),
         .left_valid  (l_valid),
         .left_x      (l_x),
         .left_y      (l_y),
         .left_key    (l_key),
         .right_valid (r_valid),
         .right_x     (r_x),
         .right_y     (r_y),
         .right_key   (r_key),
         .slot        (cell_slot[i]),
         .valid       (cell_valid[i]),
         .x           (cell_x[i]),
         .y           (cell_y[i]),
         .key         (cell_key[i])
      );
   end

   // Batch control: hold the input from the last point until the chain is empty.
   always_comb begin
      hold_in     = hold_ff;
      emit_in     = emit_ff;
      overflow_in = overflow_ff;
      if (req_take && req_tlast) begin
         hold_in = 1'b1;
      end
      if (key_valid && full) begin
         overflow_in = 1'b1;
      end
      if (key_valid && key_last) begin
         emit_in = 1'b1;
      end
      if (final_pop) begin
         hold_in     = 1'b0;
         emit_in     = 1'b0;
         overflow_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff     <= 1'b0;
         emit_ff     <= 1'b0;
         overflow_ff <= 1'b0;
      end else begin
         hold_ff     <= hold_in;
         emit_ff     <= emit_in;
         overflow_ff <= overflow_in;
      end
   end

   // Output register
   assign key0_wide   = SAT_BITS'(cell_key[0]);
   assign rsp_dist_in = (key0_wide > SAT_BITS'(DIST_MAX)) ? DIST_MAX
                                                           : DIST_BITS'(key0_wide);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_x_ff    <= cell_x[0];
         rsp_y_ff    <= cell_y[0];
         rsp_dist_ff <= rsp_dist_in;
         rsp_last_ff <= !cell_valid[1];
         rsp_drop_ff <= overflow_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({rsp_dist_ff, rsp_y_ff, rsp_x_ff});
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_drop_ff;

endmodule

// ----- hw/rtl/nps_checker.sv -----
// ----------------------------------------------------------------------------
// nps_checker: port-level checks for the nearest point sorter
// Watches batch handshakes on the top level and is bound to it below.
// ----------------------------------------------------------------------------
module nps_checker (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   input logic req_tready,
   input logic req_tlast,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic rsp_tlast
);

   // A stalled result item is not withdrawn.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp_tvalid dropped while stalled");

   // The end of a batch closes the input until the batch is delivered; this checks the closing.
   a_last_closes: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !req_tready)
      else $error("input still open after last point");

   // While a batch is still being delivered no new point is taken.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("input open during delivery of a batch");

   // Reset leaves no result pending.
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result pending after reset");

endmodule

bind nearest_point_sort_top nps_checker u_nps_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tlast  (rsp_tlast)
);

// ----- sim/nearest_point_sort_top_tb.sv -----
// ----------------------------------------------------------------------------
// nearest_point_sort_top_tb: self-checking bench for the nearest point sorter
// Streams batches of points, some directed and most random, under changing
// reference points, with random valid gaps and ready stalls. Every sorted
// item is compared field by field with a behavioral insertion-sort predictor.
// ----------------------------------------------------------------------------
module nearest_point_sort_top_tb;
   import nps_pkg::*;

   localparam int CB          = COORD_BITS_DEF;
   localparam int NPTS        = MAX_POINTS_DEF;
   localparam int REQ_W       = ((2*CB+7)/8)*8;
   localparam int RSP_W       = ((2*CB+DIST_BITS+7)/8)*8;
   localparam int RAND_ITEMS  = 236;
   localparam int QUIET_ITEMS = 60;
   localparam int DRAIN_CYCLES = 10;
   localparam int CYCLE_LIMIT = 300000;
   localparam int DIR_ROWS    = 28;
   localparam int unsigned DIST_CAP = 65535;

   // Indexes the block has no register behind; writes to them must be ignored.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_HI = 2'd3;

   typedef enum bit {ROW_POINT, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type              kind;
      logic [CSR_INDEX_BITS-1:0] idx;
      logic [CB-1:0]             a;      // point x, or register data
      logic [CB-1:0]             b;      // point y
      bit                        last;
      bit                        known;  // single-point batch with typed distance
      logic [DIST_BITS-1:0]      dist_sq;
   } stim_row_type;

   typedef struct packed {
      logic [CB-1:0]        x;
      logic [CB-1:0]        y;
      logic [DIST_BITS-1:0] dist_sq;
      logic                 last;
      logic                 dropped;
   } ranked_point_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic req_tlast = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b1;
   logic [RSP_W-1:0] rsp_tdata;
   logic rsp_tlast;
   logic rsp_tuser;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CB-1:0] csr_data = '0;

   nearest_point_sort_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Predictor state: the reference point and the sorted batch held so far.
   logic signed [CB-1:0] cur_ref_x = '0;
   logic signed [CB-1:0] cur_ref_y = '0;
   logic [CB-1:0]        held_x [NPTS];
   logic [CB-1:0]        held_y [NPTS];
   int unsigned          held_key [NPTS];
   int                   held_count = 0;
   bit                   held_overflow = 1'b0;
   ranked_point_type     sorted_q [$];

   bit gaps_on = 1'b1;
   bit stalls_on = 1'b1;
   int errors = 0;
   int checked = 0;
   int points_sent = 0;
   int batches = 0;
   int drop_batches = 0;
   int csr_writes = 0;
   int cycles = 0;
   ranked_point_type want_pt;
   stim_row_type dir_tab [DIR_ROWS];

   // Inserts one accepted point in key order behind any equal keys, and on
   // the last point of a batch queues the whole batch nearest first.
   task automatic take_point(logic [CB-1:0] x, logic [CB-1:0] y, bit last);
      int dx;
      int dy;
      int unsigned k;
      int pos;
      dx = int'(cur_ref_x) - int'($signed(x));
      dy = int'(cur_ref_y) - int'($signed(y));
      k = $unsigned(dx*dx + dy*dy);
      if (held_count >= NPTS) begin
         held_overflow = 1'b1;
      end else begin
         pos = held_count;
         while (pos > 0 && held_key[pos-1] > k) begin
            held_x[pos]   = held_x[pos-1];
            held_y[pos]   = held_y[pos-1];
            held_key[pos] = held_key[pos-1];
            pos--;
         end
         held_x[pos]   = x;
         held_y[pos]   = y;
         held_key[pos] = k;
         held_count++;
      end
      if (last) begin
         // The key sorts at full width; only the reported distance saturates.
         for (int i = 0; i < held_count; i++)
            sorted_q.push_back('{x: held_x[i], y: held_y[i],
                                 dist_sq: (held_key[i] > DIST_CAP) ? {DIST_BITS{1'b1}}
                                                                   : held_key[i][DIST_BITS-1:0],
                                 last: (i == held_count-1), dropped: held_overflow});
         if (held_overflow) drop_batches++;
         batches++;
         held_count = 0;
         held_overflow = 1'b0;
      end
   endtask

   task automatic send_point(logic [CB-1:0] x, logic [CB-1:0] y, bit last);
      if (gaps_on && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_W-2*CB){1'b0}}, y, x};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      points_sent++;
      take_point(x, y, last);
   endtask

   task automatic write_csr(logic [CSR_INDEX_BITS-1:0] idx, logic [CB-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_writes++;
      if (idx == CSR_REF_X)
         cur_ref_x = value;
      else if (idx == CSR_REF_Y)
         cur_ref_y = value;
   endtask

   // Waits for every queued item, then lets the chain settle before a write.
   task automatic drain_block();
      req_tvalid <= 1'b0;
      while (sorted_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_reference(logic [CB-1:0] rx, logic [CB-1:0] ry, bit spare);
      write_csr(CSR_REF_X, rx);
      write_csr(CSR_REF_Y, ry);
      if (spare)
         write_csr($urandom_range(0, 1) ? CSR_SPARE_HI : CSR_SPARE_LO, CB'($urandom));
      csr_valid <= 1'b0;
   endtask

   // Mixes uniform points with points clustered around the reference and
   // repeats, so that equal distances occur often.
   task automatic run_batch(int n);
      logic [CB-1:0] px;
      logic [CB-1:0] py;
      px = CB'($urandom);
      py = CB'($urandom);
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
               px = CB'($urandom);
               py = CB'($urandom);
            end
            6, 7, 8: begin
               px = cur_ref_x + CB'($urandom_range(0, 4)) - CB'(2);
               py = cur_ref_y + CB'($urandom_range(0, 4)) - CB'(2);
            end
            default: begin
               // Same point again.
            end
         endcase
         send_point(px, py, i == n-1);
      end
   endtask

   task automatic report_mismatch(string field, int unsigned got, int unsigned want);
      $display("ERROR: result %0d %s: got %0d, expected %0d", checked, field, got, want);
      errors++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (sorted_q.size() == 0) begin
            report_mismatch("arrived with nothing pending, tdata", rsp_tdata, 0);
         end else begin
            want_pt = sorted_q.pop_front();
            if (rsp_tdata[CB-1:0] !== want_pt.x)
               report_mismatch("x", rsp_tdata[CB-1:0], want_pt.x);
            if (rsp_tdata[2*CB-1:CB] !== want_pt.y)
               report_mismatch("y", rsp_tdata[2*CB-1:CB], want_pt.y);
            if (rsp_tdata[2*CB+DIST_BITS-1:2*CB] !== want_pt.dist_sq)
               report_mismatch("dist_sq", rsp_tdata[2*CB+DIST_BITS-1:2*CB], want_pt.dist_sq);
            if (rsp_tlast !== want_pt.last)
               report_mismatch("tlast", rsp_tlast, want_pt.last);
            if (rsp_tuser !== want_pt.dropped)
               report_mismatch("dropped", rsp_tuser, want_pt.dropped);
         end
         checked++;
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("ERROR: run did not finish within %0d cycles", CYCLE_LIMIT);
         $display("Mismatches found");
         $finish;
      end
   end

   // Ready stalls in random bursts while stalls are on, and stays high otherwise.
   initial begin
      forever begin
         if (stalls_on && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
      end
   end

   initial begin
      dir_tab = '{
         // Single points at the origin and two opposite corners, reference at reset.
         '{ROW_POINT, '0, CB'(0), CB'(0), 1'b1, 1'b1, 16'd0},
         '{ROW_POINT, '0, CB'(-64), CB'(-64), 1'b1, 1'b1, 16'd8192},
         '{ROW_POINT, '0, CB'(63), CB'(63), 1'b1, 1'b1, 16'd7938},
         // Three equal distances must leave in arrival order.
         '{ROW_POINT, '0, CB'(1), CB'(0), 1'b0, 1'b0, 16'd0},
         '{ROW_POINT, '0, CB'(0), CB'(1), 1'b0, 1'b0, 16'd0},
         '{ROW_POINT, '0, CB'(-1), CB'(0), 1'b1, 1'b0, 16'd0},
         // Falling distances force shifts; the ninth point, the last, is dropped.
         '{ROW_POINT, '0, CB'(8), CB'(0), 1'b0, 1'b0, 16'd0},
         '{ROW_POINT, '0, CB'(7), CB'(0), 1'b0, 1'b0, 16'd0},
         '{ROW_POINT, '0, CB'(-6), CB'(0), 1'b0, 1'b0, 16'd0},
         '{ROW_POINT, '0, CB'(5), CB'(0), 1'b0, 1'b0, 16'd0},
         '{ROW_POINT, '0, CB'(0), CB'(4), 1'b0, 1'b0, 16'd0},
         '{ROW_POINT, '0, CB'(3), CB'(0), 1'b0, 1'b0, 16'd0},
         '{ROW_POINT, '0, CB'(0), CB'(-2), 1'b0, 1'b0, 16'd0},
         '{ROW_POINT, '0, CB'(1), CB'(0), 1'b0, 1'b0, 16'd0},
         '{ROW_POINT, '0, CB'(0), CB'(0), 1'b1, 1'b0, 16'd0},
         // Reference in one corner, junk written to the unused indexes.
         '{ROW_CSR, CSR_REF_X, CB'(-64), CB'(0), 1'b0, 1'b0, 16'd0},
         '{ROW_CSR, CSR_REF_Y, CB'(63), CB'(0), 1'b0, 1'b0, 16'd0},
         '{ROW_CSR, CSR_SPARE_LO, 7'h55, CB'(0), 1'b0, 1'b0, 16'd0},
         '{ROW_CSR, CSR_SPARE_HI, 7'h2a, CB'(0), 1'b0, 1'b0, 16'd0},
         // The farthest point possible.
         '{ROW_POINT, '0, CB'(63), CB'(-64), 1'b1, 1'b1, 16'd32258},
         // Exactly a full store, with ties at distances zero, one and 16129.
         '{ROW_POINT, '0, CB'(-64), CB'(63), 1'b0, 1'b0, 16'd0},
         '{ROW_POINT, '0, CB'(63), CB'(-64), 1'b0, 1'b0, 16'd0},
         '{ROW_POINT, '0, CB'(63), CB'(63), 1'b0, 1'b0, 16'd0},
         '{ROW_POINT, '0, CB'(-64), CB'(-64), 1'b0, 1'b0, 16'd0},
         '{ROW_POINT, '0, CB'(0), CB'(0), 1'b0, 1'b0, 16'd0},
         '{ROW_POINT, '0, CB'(-64), CB'(62), 1'b0, 1'b0, 16'd0},
         '{ROW_POINT, '0, CB'(-63), CB'(63), 1'b0, 1'b0, 16'd0},
         '{ROW_POINT, '0, CB'(-64), CB'(63), 1'b1, 1'b0, 16'd0}
      };

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_tab[i]) begin
         if (dir_tab[i].kind == ROW_CSR) begin
            if (i == 0 || dir_tab[i-1].kind != ROW_CSR) drain_block();
            write_csr(dir_tab[i].idx, dir_tab[i].a);
         end else begin
            csr_valid <= 1'b0;
            send_point(dir_tab[i].a, dir_tab[i].b, dir_tab[i].last);
            if (dir_tab[i].known) begin
               // Single-point batch: the item is the point itself at the typed distance.
               void'(sorted_q.pop_back());
               sorted_q.push_back('{x: dir_tab[i].a, y: dir_tab[i].b,
                                    dist_sq: dir_tab[i].dist_sq, last: 1'b1, dropped: 1'b0});
            end
         end
      end

      begin : random_part
         int base;
         int size_pick;
         logic [CB-1:0] rx;
         logic [CB-1:0] ry;
         base = points_sent;
         while (points_sent - base < RAND_ITEMS) begin
            if (points_sent - base >= RAND_ITEMS - QUIET_ITEMS) begin
               gaps_on = 1'b0;
               stalls_on = 1'b0;
            end
            if ($urandom_range(0, 3) == 0) begin
               drain_block();
               case ($urandom_range(0, 5))
                  0: begin rx = CB'(-64); ry = CB'(-64); end
                  1: begin rx = CB'(63);  ry = CB'(63);  end
                  2: begin rx = CB'(-64); ry = CB'(63);  end
                  3: begin rx = CB'(63);  ry = CB'(-64); end
                  4: begin rx = CB'(0);   ry = CB'(0);   end
                  default: begin rx = CB'($urandom); ry = CB'($urandom); end
               endcase
               set_reference(rx, ry, $urandom_range(0, 2) == 0);
            end
            size_pick = $urandom_range(0, 19);
            if (size_pick < 14)
               run_batch($urandom_range(1, NPTS));
            else if (size_pick < 17)
               run_batch(NPTS);
            else
               run_batch($urandom_range(NPTS+1, NPTS+4));
         end
      end

      drain_block();
      $display("Sent %0d points in %0d batches (%0d with dropped points), %0d csr writes.",
               points_sent, batches, drop_batches, csr_writes);
      $display("Checked %0d sorted items against the predictor.", checked);
      if (errors == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

// ----- filelist.f -----
hw/rtl/nps_pkg.sv
hw/rtl/nps_dist.sv
hw/rtl/nps_cell.sv
hw/rtl/nearest_point_sort_top.sv
hw/rtl/nps_checker.sv
sim/nearest_point_sort_top_tb.sv
